>>> design/bmse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared types and constants for the binned mean / standard error core.
// ----------------------------------------------------------------------------
package bmse_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_BIN_DEF = 1024;

    localparam int CFG_W  = 11;
    localparam int BIN_W  = 16;
    localparam int MEAN_W = 32;
    localparam int ERR_W  = 31;

    localparam logic [CFG_W-1:0] BIN_SIZE_RST = CFG_W'(10);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t    sample_a;
        sample_t    sample_b;
        sample_t    sample_c;
        sample_t    sample_d;
        logic       end_of_data;
    } in_beat_t;

    typedef struct packed {
        logic [BIN_W-1:0]         bin_number;
        logic signed [MEAN_W-1:0] mean_a;
        logic signed [MEAN_W-1:0] mean_b;
        logic signed [MEAN_W-1:0] mean_c;
        logic signed [MEAN_W-1:0] mean_d;
        logic [ERR_W-1:0]         err_a;
        logic [ERR_W-1:0]         err_b;
        logic [ERR_W-1:0]         err_c;
        logic [ERR_W-1:0]         err_d;
    } out_beat_t;

    // lane -> merge status
    typedef struct packed {
        logic                     done;
        logic signed [MEAN_W-1:0] mean;
        logic [ERR_W-1:0]         err;
    } lane_res_t;

endpackage
`default_nettype wire

>>> design/bmse_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmse_lane
// One channel: sum / sum-of-squares accumulators plus a bit-serial finisher
// (shift-add multiplies, restoring divides, digit-by-digit square root).
// ----------------------------------------------------------------------------
module bmse_lane #(
    parameter int MAX_BIN = bmse_pkg::MAX_BIN_DEF,
    localparam int NB = $clog2(MAX_BIN + 1),
    localparam int DW = 3 * NB
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 acc_en,
    input  wire logic                 close,
    input  wire bmse_pkg::sample_t    sample,
    input  wire logic [NB-1:0]        n_in,
    input  wire logic [DW-1:0]        err_div,
    input  wire logic                 release_en,
    output bmse_pkg::lane_res_t       res
);
    import bmse_pkg::*;

    localparam int LB   = $clog2(MAX_BIN);
    localparam int SUMW = SAMPLE_BITS + LB;
    localparam int SQW  = 2 * SAMPLE_BITS - 1 + LB;
    localparam int VW   = SQW + NB;
    localparam int PW   = 2 * SUMW;
    localparam int XW   = (VW > PW) ? VW : PW;
    localparam int MW   = SUMW + 8;
    localparam int QW   = VW + 16;
    localparam int CW   = $clog2(QW + 1);
    localparam int MX   = MW + 33;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULA = 3'd1;
    localparam logic [2:0] ST_MULB = 3'd2;
    localparam logic [2:0] ST_DIVM = 3'd3;
    localparam logic [2:0] ST_DIVE = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic signed [SUMW-1:0] sum_reg, sum_next;
    logic [SQW-1:0]         sq_reg, sq_next;
    logic                   neg_reg, neg_next;
    logic [SUMW-1:0]        mag_reg, mag_next;
    logic [SUMW-1:0]        mop_reg, mop_next;
    logic [SQW-1:0]         wsq_reg, wsq_next;
    logic [NB-1:0]          n_reg, n_next;
    logic [VW-1:0]          prod_reg, prod_next;
    logic [PW-1:0]          msq_reg, msq_next;
    logic [QW-1:0]          dq_reg, dq_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [MEAN_W-1:0]      mean_reg, mean_next;
    logic [ERR_W-1:0]       err_reg, err_next;
    logic [61:0]            sx_reg, sx_next;
    logic [30:0]            root_reg, root_next;
    logic [32:0]            srem_reg, srem_next;

    logic signed [SUMW-1:0]          samp_ext, sum_add;
    logic signed [2*SAMPLE_BITS-1:0] sqr_full;
    logic [SQW-1:0]                  sq_add;
    logic [DW-1:0]                   divisor;
    logic [DW:0]                     rem2;
    logic                            qbit;
    logic [QW-1:0]                   dq_step;
    logic [DW-1:0]                   rem_step;
    logic [MX-1:0]                   qm, qsat;
    logic [XW-1:0]                   vdiff;
    logic [34:0]                     st, strial;

    assign samp_ext = SUMW'(sample);
    assign sqr_full = sample * sample;
    assign sq_add   = SQW'($unsigned(sqr_full));
    assign sum_add  = sum_reg + samp_ext;

    // shared restoring divide step
    assign divisor  = (state_reg == ST_DIVE) ? err_div : DW'(n_reg);
    assign rem2     = {rem_reg, dq_reg[QW-1]};
    assign qbit     = (rem2 >= (DW+1)'(divisor));
    assign rem_step = qbit ? DW'(rem2 - (DW+1)'(divisor)) : DW'(rem2);
    assign dq_step  = {dq_reg[QW-2:0], qbit};

    assign qm    = MX'(dq_step[MW-1:0]);
    assign vdiff = XW'(prod_reg) - XW'(msq_reg);

    assign st     = {srem_reg, sx_reg[61:60]};
    assign strial = 35'({root_reg, 2'b01});

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        mop_next   = mop_reg;
        wsq_next   = wsq_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        msq_next   = msq_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mean_next  = mean_reg;
        err_next   = err_reg;
        sx_next    = sx_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        qsat       = '0;

        if (acc_en) begin
            if (close) begin
                sum_next   = '0;
                sq_next    = '0;
                neg_next   = sum_add[SUMW-1];
                mag_next   = sum_add[SUMW-1] ? SUMW'(-sum_add) : SUMW'(sum_add);
                wsq_next   = sq_reg + sq_add;
                n_next     = n_in;
                mop_next   = SUMW'(n_in) << (SUMW - NB);
                prod_next  = '0;
                cnt_next   = CW'(NB);
                state_next = ST_MULA;
            end else begin
                sum_next = sum_add;
                sq_next  = sq_reg + sq_add;
            end
        end

        case (state_reg)
            ST_MULA: begin
                // n * sumsq, MSB first
                prod_next = (prod_reg << 1) + (mop_reg[SUMW-1] ? VW'(wsq_reg) : '0);
                mop_next  = mop_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    mop_next   = mag_reg;
                    msq_next   = '0;
                    cnt_next   = CW'(SUMW);
                    state_next = ST_MULB;
                end
            end
            ST_MULB: begin
                // sum^2
                msq_next = (msq_reg << 1) + (mop_reg[SUMW-1] ? PW'(mag_reg) : '0);
                mop_next = mop_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    dq_next    = (QW'(mag_reg) << 8) << (QW - MW);
                    rem_next   = '0;
                    cnt_next   = CW'(MW);
                    state_next = ST_DIVM;
                end
            end
            ST_DIVM: begin
                dq_next  = dq_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if (neg_reg) begin
                        qsat      = (qm > MX'(33'h080000000)) ? MX'(33'h080000000) : qm;
                        mean_next = MEAN_W'(-qsat);
                    end else begin
                        qsat      = (qm > MX'(33'h07FFFFFFF)) ? MX'(33'h07FFFFFFF) : qm;
                        mean_next = MEAN_W'(qsat);
                    end
                    if (n_reg < NB'(2)) begin
                        err_next   = ERR_W'(256);
                        state_next = ST_DONE;
                    end else begin
                        dq_next    = QW'(VW'(vdiff)) << 16;
                        rem_next   = '0;
                        cnt_next   = CW'(QW);
                        state_next = ST_DIVE;
                    end
                end
            end
            ST_DIVE: begin
                dq_next  = dq_step;
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if ((dq_step >> 62) != '0) begin
                        err_next   = '1;
                        state_next = ST_DONE;
                    end else begin
                        sx_next    = 62'(dq_step);
                        root_next  = '0;
                        srem_next  = '0;
                        cnt_next   = CW'(31);
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                sx_next  = sx_reg << 2;
                cnt_next = cnt_reg - 1'b1;
                if (st >= strial) begin
                    srem_next = 33'(st - strial);
                    root_next = {root_reg[29:0], 1'b1};
                end else begin
                    srem_next = 33'(st);
                    root_next = {root_reg[29:0], 1'b0};
                end
                if (cnt_reg == CW'(1)) begin
                    err_next   = ERR_W'(root_next);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (release_en) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            sq_reg    <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        mop_reg  <= mop_next;
        wsq_reg  <= wsq_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        msq_reg  <= msq_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        mean_reg <= mean_next;
        err_reg  <= err_next;
        sx_reg   <= sx_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
    end

    assign res.done = (state_reg == ST_DONE);
    assign res.mean = mean_reg;
    assign res.err  = err_reg;

endmodule
`default_nettype wire

>>> design/bmse_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmse_merge
// Waits for all lanes, packs their results into the output beat register.
// ----------------------------------------------------------------------------
module bmse_merge (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire bmse_pkg::lane_res_t   lane_res [bmse_pkg::CHANNELS],
    input  wire logic [bmse_pkg::BIN_W-1:0] bin_no,
    output logic                       release_en,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bmse_pkg::out_beat_t        m_data
);
    import bmse_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg, m_data_next;
    logic      all_done;

    always_comb begin
        all_done = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            all_done = all_done & lane_res[i].done;
        end
    end

    assign release_en = all_done && (!m_valid_reg || m_ready);

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (release_en) begin
            m_valid_next           = 1'b1;
            m_data_next.bin_number = bin_no;
            m_data_next.mean_a     = lane_res[0].mean;
            m_data_next.mean_b     = lane_res[1].mean;
            m_data_next.mean_c     = lane_res[2].mean;
            m_data_next.mean_d     = lane_res[3].mean;
            m_data_next.err_a      = lane_res[0].err;
            m_data_next.err_b      = lane_res[1].err;
            m_data_next.err_c      = lane_res[2].err;
            m_data_next.err_d      = lane_res[3].err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> design/binned_mean_and_std_error_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binned_mean_and_std_error_core
// Per-channel bin mean and standard error of the mean, Q.8 outputs.
//
//   channel  direction  beat
//   s_       in         four samples + end_of_data (in_beat_t)
//   m_       out        bin number, four means, four errors (out_beat_t)
//   cfg_     in         bin_size write, no handshake
//
// A record that does not close a bin leaves s_ready high for the next one.
// A closing record starts the bit-serial lane finishers: shift-add multiplies
// (n * sumsq, sum^2), a restoring divide for the mean and, for bins of two or
// more records, a restoring divide and a square root for the error; s_ready
// stays low until handover, longer while the output register holds a beat.
// Input is taken again while the handed-over beat waits for m_ready.
// Reset (aresetn, synchronous) clears sums, counts and bin_size to 10.
// ----------------------------------------------------------------------------
module binned_mean_and_std_error_core #(
    parameter int MAX_BIN = bmse_pkg::MAX_BIN_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [bmse_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire bmse_pkg::in_beat_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output bmse_pkg::out_beat_t             m_data
);
    import bmse_pkg::*;

    localparam int NB = $clog2(MAX_BIN + 1);
    localparam int DW = 3 * NB;
    localparam int EW = (NB > CFG_W) ? NB : CFG_W;

    logic [CFG_W-1:0] bin_size_reg;
    logic [NB-1:0]    cnt_reg, cnt_next;
    logic [BIN_W-1:0] bin_no_reg;
    logic             busy_reg, busy_next;
    logic [NB-1:0]    n_fin_reg;
    logic [2*NB-1:0]  nsq_reg;
    logic [DW-1:0]    d_reg;

    logic             s_fire, close, release_en;
    logic [EW-1:0]    eff;
    logic [NB:0]      cnt_inc;
    sample_t          samples [CHANNELS];
    lane_res_t        lane_res [CHANNELS];

    assign s_ready = !busy_reg;
    assign s_fire  = s_valid && s_ready;

    // effective bin size: zero acts as one, clamp to MAX_BIN
    always_comb begin
        if (bin_size_reg == '0) begin
            eff = EW'(1);
        end else if (EW'(bin_size_reg) > EW'(MAX_BIN)) begin
            eff = EW'(MAX_BIN);
        end else begin
            eff = EW'(bin_size_reg);
        end
    end

    assign cnt_inc = (NB+1)'(cnt_reg) + 1'b1;
    assign close   = s_fire && (((EW+1)'(cnt_inc) >= (EW+1)'(eff)) || s_data.end_of_data);

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (s_fire) begin
            cnt_next = close ? '0 : NB'(cnt_inc);
        end
        if (close) begin
            busy_next = 1'b1;
        end else if (release_en) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_size_reg <= BIN_SIZE_RST;
            cnt_reg      <= '0;
            bin_no_reg   <= '0;
            busy_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                bin_size_reg <= cfg_wdata;
            end
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            if (release_en) begin
                bin_no_reg <= bin_no_reg + 1'b1;
            end
        end
    end

    // error divisor n^2 (n-1), two multiplies registered; settles long
    // before the lanes reach their error divide
    always_ff @(posedge aclk) begin
        if (close) begin
            n_fin_reg <= NB'(cnt_inc);
        end
        nsq_reg <= (2*NB)'(n_fin_reg) * (2*NB)'(n_fin_reg);
        d_reg   <= DW'(nsq_reg) * DW'(n_fin_reg - 1'b1);
    end

    assign samples[0] = s_data.sample_a;
    assign samples[1] = s_data.sample_b;
    assign samples[2] = s_data.sample_c;
    assign samples[3] = s_data.sample_d;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        bmse_lane #(
            .MAX_BIN (MAX_BIN)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .acc_en     (s_fire),
            .close      (close),
            .sample     (samples[g]),
            .n_in       (NB'(cnt_inc)),
            .err_div    (d_reg),
            .release_en (release_en),
            .res        (lane_res[g])
        );
    end

    bmse_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lane_res   (lane_res),
        .bin_no     (bin_no_reg),
        .release_en (release_en),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for binned_mean_and_std_error_core. Records go in on a
// valid/ready channel with random gaps; an in-bench model keeps the bin sums
// and predicts each closed bin's number, Q.8 means and Q.8 standard errors.
// Output beats are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import bmse_pkg::*;

    localparam int MAX_BIN    = MAX_BIN_DEF;
    localparam int DRAIN_WAIT = 320;    // covers a full finisher run plus margin
    localparam int STALL_MAX  = 13;
    localparam int WDOG_LIMIT = 5000;   // cycles with no beat on either side

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_beat_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_beat_t           m_data;

    binned_mean_and_std_error_core #(.MAX_BIN(MAX_BIN)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---- model state: mirrors the block's accumulators ----
    longint          bin_sum [CHANNELS];
    longint unsigned bin_sumsq [CHANNELS];
    int unsigned     bin_fill;
    logic [BIN_W-1:0] bins_done;
    logic [CFG_W-1:0] bin_size_reg;

    out_beat_t  pending_bins[$];   // predicted bins not yet seen on m_
    int         mismatches = 0;
    int         records_in = 0;
    int         bins_out = 0;
    int         idle_cycles = 0;
    bit         quiet = 1'b0;      // no gaps on either side
    int         rx_stall = 0;
    int         rx_hold = 0;       // long hold-off requested by a test

    // Q.8 mean, truncated toward zero, saturated to 32 bits signed
    function automatic logic signed [MEAN_W-1:0] mean_of(longint sum, int unsigned n);
        longint unsigned mag, q;
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        q   = (mag << 8) / n;
        if (sum < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return MEAN_W'(-q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return MEAN_W'(q);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Q.8 standard error of the mean, exact integer path, floored
    function automatic logic [ERR_W-1:0] sem_of(longint sum, longint unsigned sq,
                                                 int unsigned n);
        logic [127:0]    var_num, quo, mag;
        logic [63:0]     den;
        longint unsigned r;
        if (n < 2) return ERR_W'(256);
        mag     = (sum < 0) ? 128'(-sum) : 128'(sum);
        var_num = 128'(sq) * 128'(n) - mag * mag;
        var_num = var_num << 16;
        den     = 64'(n) * 64'(n) * 64'(n - 1);
        quo     = var_num / 128'(den);
        if (quo >= (128'd1 << 62)) return ERR_W'(31'h7FFF_FFFF);
        r = root_floor(quo[63:0]);
        return (r > 64'h7FFF_FFFF) ? ERR_W'(31'h7FFF_FFFF) : ERR_W'(r);
    endfunction

    task automatic accumulate_record(in_beat_t rec);
        sample_t    smp [CHANNELS];
        out_beat_t  res;
        int unsigned eff;
        smp = '{rec.sample_a, rec.sample_b, rec.sample_c, rec.sample_d};
        eff = (bin_size_reg == 0) ? 1 : (bin_size_reg > MAX_BIN) ? MAX_BIN : bin_size_reg;
        for (int i = 0; i < CHANNELS; i++) begin
            bin_sum[i]   += longint'(smp[i]);
            bin_sumsq[i] += longint'(smp[i]) * longint'(smp[i]);
        end
        bin_fill++;
        if (bin_fill >= eff || rec.end_of_data) begin
            res.bin_number = bins_done;
            res.mean_a = mean_of(bin_sum[0], bin_fill);
            res.mean_b = mean_of(bin_sum[1], bin_fill);
            res.mean_c = mean_of(bin_sum[2], bin_fill);
            res.mean_d = mean_of(bin_sum[3], bin_fill);
            res.err_a  = sem_of(bin_sum[0], bin_sumsq[0], bin_fill);
            res.err_b  = sem_of(bin_sum[1], bin_sumsq[1], bin_fill);
            res.err_c  = sem_of(bin_sum[2], bin_sumsq[2], bin_fill);
            res.err_d  = sem_of(bin_sum[3], bin_sumsq[3], bin_fill);
            pending_bins.insert(pending_bins.size(), res);
            bins_done++;
            bin_fill = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                bin_sum[i]   = 0;
                bin_sumsq[i] = 0;
            end
        end
    endtask

    task automatic report(string field, longint unsigned want, longint unsigned got);
        $display("MISMATCH bin %0d %s: expected %0h got %0h", bins_out, field, want, got);
        mismatches++;
    endtask

    // ---- monitor: sampled at the rising edge, before the block updates ----
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn) begin
            if (cfg_we) bin_size_reg = cfg_wdata;
            if (s_valid && s_ready) begin
                accumulate_record(s_data);
                records_in++;
            end
            if (m_valid && m_ready) begin
                if (pending_bins.size() == 0) begin
                    report("unexpected beat, bin_number", 0, m_data.bin_number);
                end else begin
                    want = pending_bins.pop_front();
                    if (m_data.bin_number !== want.bin_number)
                        report("bin_number", want.bin_number, m_data.bin_number);
                    if (m_data.mean_a !== want.mean_a) report("mean_a", want.mean_a, m_data.mean_a);
                    if (m_data.mean_b !== want.mean_b) report("mean_b", want.mean_b, m_data.mean_b);
                    if (m_data.mean_c !== want.mean_c) report("mean_c", want.mean_c, m_data.mean_c);
                    if (m_data.mean_d !== want.mean_d) report("mean_d", want.mean_d, m_data.mean_d);
                    if (m_data.err_a !== want.err_a) report("err_a", want.err_a, m_data.err_a);
                    if (m_data.err_b !== want.err_b) report("err_b", want.err_b, m_data.err_b);
                    if (m_data.err_c !== want.err_c) report("err_c", want.err_c, m_data.err_c);
                    if (m_data.err_d !== want.err_d) report("err_d", want.err_d, m_data.err_d);
                end
                bins_out++;
                rx_stall = quiet ? 0 : $urandom_range(STALL_MAX, 0);
            end
            idle_cycles = ((s_valid && s_ready) || (m_valid && m_ready)) ? 0 : idle_cycles + 1;
        end
    end

    // ---- receiver: m_ready moves on the falling edge ----
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (rx_hold > 0) begin
            m_ready = 1'b0;
            rx_hold--;
        end else if (rx_stall > 0) begin
            m_ready = 1'b0;
            rx_stall--;
        end else begin
            m_ready = 1'b1;
        end
    end

    initial begin
        while (idle_cycles < WDOG_LIMIT) @(posedge aclk);
        $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
        $display("testbench failed");
        $finish;
    end

    // One record beat: optional gap, then hold valid until taken.
    // Called at a falling edge, returns at the falling edge after acceptance.
    task automatic send_record(in_beat_t rec);
        int gap;
        gap = quiet ? 0 : $urandom_range(STALL_MAX, 0);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = rec;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drop_valid();
        s_valid = 1'b0;
    endtask

    function automatic in_beat_t rand_record(bit eod);
        in_beat_t r;
        r.sample_a = sample_t'($urandom);
        r.sample_b = sample_t'($urandom);
        r.sample_c = sample_t'($urandom);
        r.sample_d = sample_t'($urandom);
        r.end_of_data = eod;
        return r;
    endfunction

    function automatic in_beat_t flat_record(sample_t v, bit eod);
        in_beat_t r;
        r.sample_a = v;
        r.sample_b = -v;
        r.sample_c = v;
        r.sample_d = sample_t'(0);
        r.end_of_data = eod;
        return r;
    endfunction

    // Wait for all bins to drain, then long enough that a bin still in the
    // finisher would have shown up too.
    task automatic wait_drained();
        drop_valid();
        wait (pending_bins.size() == 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_bin_size(logic [CFG_W-1:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    // ---- tests ----
    task automatic test_directed();
        // reset size of 10: extremes, then an early close
        send_record(flat_record(sample_t'(24'h7FFFFF), 1'b0));
        send_record(flat_record(sample_t'(24'h800000), 1'b0));
        send_record(flat_record(sample_t'(0), 1'b0));
        send_record(flat_record(sample_t'(-1), 1'b1));       // end-of-data close
        send_record(flat_record(sample_t'(24'h123456), 1'b1)); // one-sample bin
        for (int i = 0; i < 10; i++)                            // full bin of max
            send_record(flat_record(sample_t'(24'h7FFFFF), 1'b0));
        for (int i = 0; i < 10; i++)                            // alternating extremes
            send_record(flat_record(i[0] ? sample_t'(24'h800000) : sample_t'(24'h7FFFFF),
                                    1'b0));
    endtask

    task automatic test_size_lowered_mid_bin();
        write_bin_size(CFG_W'(10));
        for (int i = 0; i < 6; i++) send_record(rand_record(1'b0));
        write_bin_size(CFG_W'(3));      // bin already past the new size
        send_record(rand_record(1'b0));
        send_record(rand_record(1'b0));
    endtask

    task automatic test_size_extremes();
        write_bin_size(CFG_W'(0));      // acts as one
        for (int i = 0; i < 8; i++) send_record(rand_record(1'b0));
        write_bin_size(CFG_W'(1));
        for (int i = 0; i < 8; i++) send_record(rand_record(i == 3));
        write_bin_size(CFG_W'(2047));   // capped at the max bin
        quiet = 1'b1;
        for (int i = 0; i < MAX_BIN + 3; i++)
            send_record(flat_record(i[0] ? sample_t'(24'h800000) : sample_t'(24'h7FFFFF),
                                    1'b0));
        send_record(rand_record(1'b1));
        quiet = 1'b0;
        write_bin_size(CFG_W'(1024));
        for (int i = 0; i < 30; i++) send_record(rand_record(1'b0));
        send_record(rand_record(1'b1));
    endtask

    task automatic test_backpressure();
        write_bin_size(CFG_W'(2));
        quiet = 1'b1;
        @(posedge aclk);
        rx_hold = 1500;                 // receiver off while records keep coming
        @(negedge aclk);
        for (int i = 0; i < 20; i++) send_record(rand_record(1'b0));
        quiet = 1'b0;
    endtask

    task automatic test_random();
        int sz;
        for (int phase = 0; phase < 12; phase++) begin
            sz = (phase % 4 == 3) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            write_bin_size(CFG_W'(sz));
            quiet = (phase == 5);
            for (int i = 0; i < 50; i++)
                send_record(rand_record($urandom_range(15, 0) == 0));
        end
        quiet = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            bin_sum[i]   = 0;
            bin_sumsq[i] = 0;
        end
        bin_fill     = 0;
        bins_done    = '0;
        bin_size_reg = BIN_SIZE_RST;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_size_lowered_mid_bin();
        test_size_extremes();
        test_backpressure();
        test_random();

        wait_drained();
        $display("covered %0d records and %0d bins: bin sizes 0, 1, 2..40, 1024, 2047,",
                 records_in, bins_out);
        $display("end-of-data closes, a size cut mid-bin, and a long output hold-off");
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
